// ===== hdl/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256/224 block hash.
// Holds the item structs, the sequencer control word and step program,
// the initial hash values and the round constant table. No dependencies.
package sha256_pkg;

  // Input item: one message word plus the final-block mark
  typedef struct packed {
    logic [31:0] message_word;
    logic        message_end;
  } msg_item_t;

  // Result item: one digest word with its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  // Chaining value as eight words, word 0 first (a)
  typedef logic [7:0][31:0] hash_words_t;

  // Sequencer steps (program addresses)
  typedef enum logic [2:0] {
    STEP_LOAD  = 3'd0,
    STEP_INIT  = 3'd1,
    STEP_ROUND = 3'd2,
    STEP_ADD   = 3'd3,
    STEP_EMIT  = 3'd4
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS     = 3'd0,
    COND_WORD_DONE  = 3'd1,
    COND_ROUND_DONE = 3'd2,
    COND_END_SEEN   = 3'd3,
    COND_BUF_FREE   = 3'd4
  } cond_t;

  // One microcode word: datapath actions plus a two-way branch
  typedef struct packed {
    logic  load;
    logic  init;
    logic  round;
    logic  add;
    logic  emit;
    cond_t cond;
    step_t jump_true;
    step_t jump_false;
  } ctrl_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic word_last;
    logic round_last;
    logic end_seen;
  } dp_status_t;

  localparam int unsigned WORDS_PER_BLOCK = 16;
  localparam int unsigned ROUNDS          = 64;
  localparam logic [3:0]  DIGEST_LEN_256  = 4'd8;
  localparam logic [3:0]  DIGEST_LEN_224  = 4'd7;

  localparam hash_words_t IV_256 = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam hash_words_t IV_224 = {
    32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
    32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
  };

  // Microcode program
  function automatic ctrl_t step_rom(input step_t step);
    ctrl_t c;
    c = '{load: 1'b0, init: 1'b0, round: 1'b0, add: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, jump_true: STEP_LOAD, jump_false: STEP_LOAD};
    case (step)
      STEP_LOAD: begin
        c.load       = 1'b1;
        c.cond       = COND_WORD_DONE;
        c.jump_true  = STEP_INIT;
        c.jump_false = STEP_LOAD;
      end
      STEP_INIT: begin
        c.init       = 1'b1;
        c.cond       = COND_ALWAYS;
        c.jump_true  = STEP_ROUND;
        c.jump_false = STEP_ROUND;
      end
      STEP_ROUND: begin
        c.round      = 1'b1;
        c.cond       = COND_ROUND_DONE;
        c.jump_true  = STEP_ADD;
        c.jump_false = STEP_ROUND;
      end
      STEP_ADD: begin
        c.add        = 1'b1;
        c.cond       = COND_END_SEEN;
        c.jump_true  = STEP_EMIT;
        c.jump_false = STEP_LOAD;
      end
      STEP_EMIT: begin
        c.emit       = 1'b1;
        c.cond       = COND_BUF_FREE;
        c.jump_true  = STEP_LOAD;
        c.jump_false = STEP_EMIT;
      end
      default: begin
        c.cond       = COND_ALWAYS;
        c.jump_true  = STEP_LOAD;
        c.jump_false = STEP_LOAD;
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/sha256_seq.sv =====
// Microcode sequencer: step register, program table lookup and branch.
// Depends on sha256_pkg for the step, condition and control word types.
module sha256_seq
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  logic       word_taken,
  input  dp_status_t status,
  input  logic       buf_free,
  output ctrl_t      ctrl
);

  step_t step;
  step_t step_next;
  logic  cond_hit;

  // Fetch the control word of the current step
  always_comb begin
    ctrl = step_rom(step);
  end

  // Evaluate the branch condition
  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_WORD_DONE:  cond_hit = word_taken & status.word_last;
      COND_ROUND_DONE: cond_hit = status.round_last;
      COND_END_SEEN:   cond_hit = status.end_seen;
      COND_BUF_FREE:   cond_hit = buf_free;
      default:         cond_hit = 1'b1;
    endcase
  end

  // Pick the next step
  always_comb begin
    step_next = cond_hit ? ctrl.jump_true : ctrl.jump_false;
  end

  // Advance the step register; a config write restarts the program
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/sha256_datapath.sv =====
// Hash datapath: schedule shift window, working variables, round counter,
// chaining value and variant register. Depends on sha256_pkg.
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_variant,
  input  ctrl_t       ctrl,
  input  logic        load_go,
  input  logic        emit_go,
  input  msg_item_t   item,
  output dp_status_t  status,
  output hash_words_t chain,
  output logic        use_224
);

  logic [31:0] window [WORDS_PER_BLOCK];
  logic [31:0] wv [8];
  logic [5:0]  round_cnt;
  logic [3:0]  word_count;
  logic        end_seen;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  // Schedule expansion and one compression round
  always_comb begin
    w_new = small_sigma1(window[14]) + window[9] + small_sigma0(window[1]) + window[0];
    t1 = wv[7] + big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
         + round_k(round_cnt) + window[0];
    t2 = big_sigma0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Shift the window: message words during load, expanded words during rounds
  always_ff @(posedge clk) begin
    if (load_go || ctrl.round) begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[WORDS_PER_BLOCK - 1] <= load_go ? item.message_word : w_new;
    end
  end

  // Working variables: copy in at init, rotate each round
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (ctrl.round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  // Count rounds
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      round_cnt <= '0;
    end else if (ctrl.round) begin
      round_cnt <= round_cnt + 6'd1;
    end
  end

  // Count words and remember the final-block mark
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      word_count <= '0;
      end_seen   <= 1'b0;
    end else begin
      if (load_go) begin
        word_count <= word_count + 4'd1;
      end
      if (load_go && item.message_end) begin
        end_seen <= 1'b1;
      end else if (emit_go) begin
        end_seen <= 1'b0;
      end
    end
  end

  // Variant register and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      use_224 <= 1'b0;
      chain   <= IV_256;
    end else if (cfg_we) begin
      use_224 <= cfg_variant;
      chain   <= cfg_variant ? IV_224 : IV_256;
    end else if (emit_go) begin
      chain <= use_224 ? IV_224 : IV_256;
    end else if (ctrl.add) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end
  end

  assign status.word_last  = (word_count == 4'(WORDS_PER_BLOCK - 1));
  assign status.round_last = (round_cnt == 6'(ROUNDS - 1));
  assign status.end_seen   = end_seen;

endmodule

// ===== hdl/sha256_out_buf.sv =====
// Digest output buffer: holds a finished digest and shifts it out one item
// at a time, so the datapath can take the next message. Depends on sha256_pkg.
module sha256_out_buf
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fill,
  input  hash_words_t  chain,
  input  logic [3:0]   total,
  output logic         buf_free,
  output logic         valid,
  input  logic         stall,
  output digest_item_t item
);

  hash_words_t words;
  logic [3:0]  remain;
  logic [2:0]  index;
  logic        take;

  assign take = valid & ~stall;

  // Hold the digest; drop the front word on each delivered item
  always_ff @(posedge clk) begin
    if (fill) begin
      words <= chain;
    end else if (take) begin
      words <= {32'h0, words[7:1]};
    end
  end

  // Track remaining items and the index of the front word
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      index  <= '0;
    end else if (fill) begin
      remain <= total;
      index  <= '0;
    end else if (take) begin
      remain <= remain - 4'd1;
      index  <= index + 3'd1;
    end
  end

  assign valid    = (remain != 4'd0);
  assign buf_free = ~valid;

  assign item.digest_word = words[0];
  assign item.word_index  = index;
  assign item.last_word   = (remain == 4'd1);

endmodule

// ===== hdl/sha256_block_hash.sv =====
// SHA-256 / SHA-224 block hash: top level.
// Instantiates sha256_seq, sha256_datapath and sha256_out_buf; uses sha256_pkg.
//
// Usage:
//   message channel: padded message words, big-endian, sixteen per block.
//     An item moves when message_valid is high and message_stall is low.
//     message_end set on any word of a block marks it as the final block.
//   digest channel: after the final block, 8 words (SHA-256) or 7 words
//     (SHA-224), word_index 0 first, last_word on the final one.
//   config_write_enable / config_write_data: variant select, 1 = SHA-224.
//     A write reloads the initial values and restarts the message; write
//     only while the block is idle.
// Timing: while loading, a word is taken whenever message_valid is high.
//   After the sixteenth word of a 512-bit block the block stalls through a
//   setup step, the rounds at one per cycle through a single round unit
//   and a chaining add, plus, on a final block, a hand-off step that gives
//   the digest to the output buffer.
// The digest buffer lets the next message load while the digest drains; if
//   the receiver still stalls the previous digest when the next final block
//   finishes, the block waits in its hand-off step until the buffer empties.
// Reset (rst, synchronous) selects SHA-256 and clears all control state.
module sha256_block_hash
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         config_write_enable,
  input  logic         config_write_data,
  input  logic         message_valid,
  output logic         message_stall,
  input  msg_item_t    message,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest
);

  ctrl_t       ctrl;
  dp_status_t  status;
  hash_words_t chain;
  logic        use_224;
  logic        buf_free;
  logic        load_go;
  logic        emit_go;

  // Take a word only in the load step
  assign message_stall = ~ctrl.load;
  assign load_go       = message_valid & ~message_stall;
  assign emit_go       = ctrl.emit & buf_free;

  sha256_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .restart    (config_write_enable),
    .word_taken (load_go),
    .status     (status),
    .buf_free   (buf_free),
    .ctrl       (ctrl)
  );

  sha256_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (config_write_enable),
    .cfg_variant (config_write_data),
    .ctrl        (ctrl),
    .load_go     (load_go),
    .emit_go     (emit_go),
    .item        (message),
    .status      (status),
    .chain       (chain),
    .use_224     (use_224)
  );

  sha256_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .fill     (emit_go),
    .chain    (chain),
    .total    (use_224 ? DIGEST_LEN_224 : DIGEST_LEN_256),
    .buf_free (buf_free),
    .valid    (digest_valid),
    .stall    (digest_stall),
    .item     (digest)
  );

endmodule
